// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;

    localparam int POOL_LOG2      = 20;
    localparam int MIN_BLOCK_LOG2 = 10;
    localparam int LEVELS         = POOL_LOG2 - MIN_BLOCK_LOG2;
    localparam int NODE_COUNT     = (1 << (LEVELS + 1)) - 1;
    localparam int INNER_COUNT    = (1 << LEVELS) - 1;
    localparam int NODE_W         = LEVELS + 1;
    localparam int LVL_W          = $clog2(LEVELS + 1);

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
    localparam logic [1:0] ST_NO_MEMORY = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic        action;
        logic [20:0] request_size;
        logic [19:0] block_offset;
    } bba_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] result_offset;
    } bba_out_t;

    // Node state as held in memory: allocated and split bits
    typedef struct packed {
        logic alloc;
        logic split;
    } node_bits_t;

    // Memory access request from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        node_bits_t        wr_data;
    } mem_req_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SCAN,
        S_A_PAR,
        S_A_CHK,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_M_RD,
        S_M_CHK,
        S_DONE
    } bba_state_t;

endpackage

// ===== rtl/bba_node_mem.sv =====
`timescale 1ns / 1ps
module bba_node_mem (
    input  logic                      aclk,
    input  bba_pkg::mem_req_t         req,
    output bba_pkg::node_bits_t       rd_data
);
    import bba_pkg::*;

    // one entry per tree node; leaves simply never set the split bit
    node_bits_t mem [NODE_COUNT];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== rtl/bba_ctrl.sv =====
`timescale 1ns / 1ps
module bba_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bba_pkg::bba_in_t      s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bba_pkg::bba_out_t     m_data,
    output bba_pkg::mem_req_t     mreq,
    input  bba_pkg::node_bits_t   rd_data
);
    import bba_pkg::*;

    bba_state_t state_reg, state_next;
    logic [NODE_W-1:0] node_reg, node_next;    // node under test
    logic [LVL_W-1:0]  lvl_reg, lvl_next;      // current level
    logic [LVL_W-1:0]  tgt_reg, tgt_next;      // target level
    logic [19:0]       off_reg, off_next;
    logic              cand_reg, cand_next;    // node itself free and unsplit
    logic              out_valid_reg, out_valid_next;
    bba_out_t          res_reg, res_next;      // result being built
    bba_out_t          out_reg, out_next;

    logic [NODE_W-1:0] parent;
    logic [NODE_W-1:0] sib;
    logic [NODE_W-1:0] lvl_first;
    logic [NODE_W-1:0] lvl_end;
    logic [NODE_W-1:0] tgt_first;
    logic [LVL_W-1:0]  tgt_calc;
    logic              off_aligned;
    logic [NODE_W-1:0] free_node;
    logic [19:0]       alloc_off;

    assign parent    = (node_reg - 1'b1) >> 1;
    assign sib       = node_reg[0] ? node_reg + 1'b1 : node_reg - 1'b1;
    assign lvl_first = NODE_W'((1 << lvl_reg) - 1);
    assign lvl_end   = NODE_W'((2 << lvl_reg) - 1);
    assign tgt_first = NODE_W'((1 << tgt_reg) - 1);
    assign alloc_off = 20'(32'(node_reg - tgt_first) << (POOL_LOG2 - tgt_reg));
    assign off_aligned = (32'(off_reg) & ((32'd1 << (POOL_LOG2 - lvl_reg)) - 1)) == 0;
    assign free_node = NODE_W'(lvl_first + NODE_W'(off_reg >> (POOL_LOG2 - lvl_reg)));

    // target level from size: smallest block that holds it
    always_comb begin
        tgt_calc = LVL_W'(LEVELS);
        for (int k = LEVELS; k > 0; k--) begin
            if ((33'd1 << (POOL_LOG2 - k)) < 33'(s_data.request_size)) begin
                if (tgt_calc == LVL_W'(k)) tgt_calc = LVL_W'(k - 1);
            end
        end
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        node_next = node_reg;
        lvl_next = lvl_reg;
        tgt_next = tgt_reg;
        off_next = off_reg;
        cand_next = cand_reg;
        out_valid_next = out_valid_reg;
        res_next = res_reg;
        out_next = out_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                if (node_reg == NODE_W'(NODE_COUNT - 1)) state_next = S_IDLE;
                node_next = node_reg + 1'b1;
            end
            S_IDLE: begin
                if (s_valid) begin
                    off_next = s_data.block_offset;
                    res_next = '0;
                    if (!s_data.action) begin
                        if (s_data.request_size == 0 ||
                            s_data.request_size > 21'(1 << POOL_LOG2)) begin
                            res_next.status = ST_BAD_SIZE;
                            state_next = S_DONE;
                        end else begin
                            tgt_next = tgt_calc;
                            lvl_next = tgt_calc;
                            node_next = NODE_W'((1 << tgt_calc) - 1);
                            state_next = S_A_SCAN;
                        end
                    end else begin
                        lvl_next = LVL_W'(LEVELS);
                        state_next = S_F_RD;
                    end
                end
            end
            // node read issued; check it, then its parent
            S_A_SCAN: state_next = S_A_PAR;
            S_A_PAR: begin
                cand_next = !rd_data.alloc && !rd_data.split;
                state_next = S_A_CHK;
            end
            S_A_CHK: begin
                if (cand_reg && (node_reg == 0 || rd_data.split)) begin
                    if (lvl_reg == tgt_reg) begin
                        res_next.result_offset = alloc_off;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_A_SPLIT;
                    end
                end else if (node_reg + 1'b1 < lvl_end) begin
                    node_next = node_reg + 1'b1;
                    state_next = S_A_SCAN;
                end else if (lvl_reg == 0) begin
                    res_next.status = ST_NO_MEMORY;
                    state_next = S_DONE;
                end else begin
                    lvl_next = lvl_reg - 1'b1;
                    node_next = NODE_W'((1 << (lvl_reg - 1'b1)) - 1);
                    state_next = S_A_SCAN;
                end
            end
            // mark split, walk left; allocate at target
            S_A_SPLIT: begin
                if (lvl_reg == tgt_reg) begin
                    res_next.result_offset = alloc_off;
                    state_next = S_DONE;
                end else begin
                    node_next = {node_reg[NODE_W-2:0], 1'b1};
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            S_F_RD: begin
                if (!off_aligned) begin
                    if (lvl_reg == 0) begin
                        res_next.status = ST_BAD_FREE;
                        state_next = S_DONE;
                    end else begin
                        lvl_next = lvl_reg - 1'b1;
                    end
                end else begin
                    node_next = free_node;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (rd_data.alloc) begin
                    state_next = (node_reg == 0) ? S_DONE : S_M_RD;
                end else if (lvl_reg == 0) begin
                    res_next.status = ST_BAD_FREE;
                    state_next = S_DONE;
                end else begin
                    lvl_next = lvl_reg - 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_M_RD: state_next = S_M_CHK;
            S_M_CHK: begin
                if (rd_data.alloc || rd_data.split) begin
                    state_next = S_DONE;
                end else begin
                    node_next = parent;
                    state_next = (parent == 0) ? S_DONE : S_M_RD;
                end
            end
            // hand the result to the output register once it is free
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory requests and handshake outputs
    always_comb begin
        mreq = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                mreq.wr_en = 1'b1;
                mreq.wr_addr = node_reg;
            end
            S_IDLE: s_ready = 1'b1;
            S_A_SCAN: begin
                mreq.rd_en = 1'b1;
                mreq.rd_addr = node_reg;
            end
            S_A_PAR: begin
                mreq.rd_en = 1'b1;
                mreq.rd_addr = parent;
            end
            S_A_CHK: begin
                if (cand_reg && (node_reg == 0 || rd_data.split) && lvl_reg == tgt_reg) begin
                    mreq.wr_en = 1'b1;
                    mreq.wr_addr = node_reg;
                    mreq.wr_data = '{alloc: 1'b1, split: 1'b0};
                end
            end
            S_A_SPLIT: begin
                mreq.wr_en = 1'b1;
                mreq.wr_addr = node_reg;
                mreq.wr_data = (lvl_reg == tgt_reg) ? node_bits_t'{alloc: 1'b1, split: 1'b0}
                                                    : node_bits_t'{alloc: 1'b0, split: 1'b1};
            end
            S_F_RD: begin
                mreq.rd_en = off_aligned;
                mreq.rd_addr = free_node;
            end
            S_F_CHK: begin
                if (rd_data.alloc) begin
                    mreq.wr_en = 1'b1;
                    mreq.wr_addr = node_reg;
                    mreq.wr_data = '{alloc: 1'b0, split: 1'b0};
                end
            end
            S_M_RD: begin
                mreq.rd_en = 1'b1;
                mreq.rd_addr = sib;
            end
            S_M_CHK: begin
                if (!(rd_data.alloc || rd_data.split)) begin
                    mreq.wr_en = 1'b1;
                    mreq.wr_addr = parent;
                    mreq.wr_data = '{alloc: 1'b0, split: 1'b0};
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            node_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            node_reg <= node_next;
            out_valid_reg <= out_valid_next;
        end
        lvl_reg <= lvl_next;
        tgt_reg <= tgt_next;
        off_reg <= off_next;
        cand_reg <= cand_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready) else $error("accept during clear");
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("word dropped");
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mreq.rd_en && mreq.wr_en)) else $error("read and write together");
    a_ok_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.result_offset == 0)
        else $error("offset on failure");
`endif

endmodule

// ===== rtl/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// Binary buddy allocator over a 1 MiB pool with 1 KiB minimum blocks.
// Input channel s_*: one word per request; action 0 allocates request_size
// bytes, action 1 frees the block at block_offset.
// Result channel m_*: exactly one word per request, status and offset.
// Node state (allocated and split bits, 2047 nodes) lives in one
// synchronous RAM with a registered read port; each step of the tree
// walk does at most one RAM access.
// Allocate scans the nodes of the target level, reading each node and
// its parent, and moves up a level when none fits; a free block found
// above the target is split level by level down its left side.
// Free skips the levels at which block_offset is unaligned, probes each
// aligned level for an allocated node, then merges while the sibling is free.
// One request is in flight at a time.
// Reset: a clearing pass writes every node; s_ready stays low meanwhile.
// A stalled receiver holds the result word in the output register; the
// next request is taken but its result waits until that word is taken.
module buddy_block_allocator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bba_pkg::bba_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bba_pkg::bba_out_t   m_data
);
    import bba_pkg::*;

    mem_req_t   mreq;
    node_bits_t rd_data;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    bba_node_mem u_mem (
        .aclk    (aclk),
        .req     (mreq),
        .rd_data (rd_data)
    );

endmodule
